>>> rtl/core/mau_pkg.sv
// ----------------------------------------------------------------------------
// mau_pkg
// Types and constants shared by the modular arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

   localparam int unsigned VW = 31;
   localparam int unsigned EW = 64;
   localparam int unsigned KW = 3;
   localparam int unsigned PW = 2 * VW;
   localparam logic [VW-1:0] MOD_RESET = 31'd1000000007;

   localparam logic [KW-1:0] K_ADD = 3'd0;
   localparam logic [KW-1:0] K_SUB = 3'd1;
   localparam logic [KW-1:0] K_MUL = 3'd2;
   localparam logic [KW-1:0] K_NEG = 3'd3;
   localparam logic [KW-1:0] K_POW = 3'd4;
   localparam logic [KW-1:0] K_INV = 3'd5;
   localparam logic [KW-1:0] K_DIV = 3'd6;
   localparam logic [KW-1:0] K_EQ  = 3'd7;

   typedef struct packed {
      logic [KW-1:0] kind;
      logic [VW-1:0] operand_a;
      logic [VW-1:0] operand_b;
      logic [EW-1:0] exponent;
   } mau_req_type;

   typedef struct packed {
      logic [VW-1:0] result;
      logic          equal;
   } mau_rsp_type;

endpackage

>>> rtl/core/mau_mulmod.sv
// ----------------------------------------------------------------------------
// mau_mulmod
// Shared modular multiplier: forms the 62-bit product, then a 2-bit-per-cycle
// shift/subtract reduction of that product.
// ----------------------------------------------------------------------------
module mau_mulmod (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  logic [mau_pkg::VW-1:0] x,
   input  logic [mau_pkg::VW-1:0] y,
   input  logic [mau_pkg::VW-1:0] m,
   output logic                  done,
   output logic [mau_pkg::VW-1:0] r
);
   import mau_pkg::*;

   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [VW-1:0] r_ff, r_in;
   logic [VW:0]   t1, t2, mx;
   logic [VW-1:0] u1;

   always_comb begin
      mx = {1'b0, m};
      t1 = {r_ff, prod_ff[PW-1]};
      if (t1 >= mx) begin
         t1 = t1 - mx;
      end
      u1 = t1[VW-1:0];
      t2 = {u1, prod_ff[PW-2]};
      if (t2 >= mx) begin
         t2 = t2 - mx;
      end
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      prod_in = prod_ff;
      r_in    = r_ff;
      if (go) begin
         prod_in = PW'(x) * PW'(y);
         r_in    = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         prod_in = {prod_ff[PW-3:0], 2'b00};
         r_in    = t2[VW-1:0];
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'd30) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      prod_ff <= prod_in;
      r_ff    <= r_in;
   end

   assign done = done_ff;
   assign r    = r_ff;

endmodule

>>> rtl/core/modular_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Modular add/sub/mul/neg/pow/inverse/divide/equality over a set modulus.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low; req_data holds
//   kind, operands and exponent. Exactly one result per transaction appears
//   on rsp_data for one cycle with rsp_valid high; it cannot be held off.
//   csr_we writes the modulus (reset value 1000000007); the user must write it
//   only while idle; the block itself does not enforce this.
//   Each modular multiply runs on the shared mulmod unit (a product step
//   plus 2-bit reduction steps). Both operands are first reduced by it
//   (2 multiplies). add/sub/neg/eq then finish directly, mul takes one more
//   multiply, pow squares once per exponent bit up to its top set bit and
//   multiplies once more per set bit, inv does the same with exponent
//   modulus-2, and div that plus one more multiply.
//   One transaction at a time; busy stays high until the result strobe.
// Reset:
//   Synchronous active-high reset returns to idle and restores the modulus.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  mau_pkg::mau_req_type   req_data,
   output logic                   rsp_valid,
   output mau_pkg::mau_rsp_type   rsp_data,
   input  logic                   csr_we,
   input  logic [mau_pkg::VW-1:0] csr_wdata
);
   import mau_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RA   = 4'd1;
   localparam logic [3:0] S_RB   = 4'd2;
   localparam logic [3:0] S_OP   = 4'd3;
   localparam logic [3:0] S_PL   = 4'd4;
   localparam logic [3:0] S_PY   = 4'd5;
   localparam logic [3:0] S_PX   = 4'd6;
   localparam logic [3:0] S_MM   = 4'd7;

   logic [3:0]    state_ff, state_in;
   logic [VW-1:0] mod_ff, mod_in;
   logic [KW-1:0] kind_ff, kind_in;
   logic [VW-1:0] a_ff, a_in, b_ff, b_in, x_ff, x_in, y_ff, y_in;
   logic [EW-1:0] k_ff, k_in;
   logic [VW-1:0] mx_ff, mx_in, my_ff, my_in;
   logic          go_ff, go_in;
   logic          vld_ff, vld_in;
   mau_rsp_type   rsp_ff, rsp_in;

   logic [VW-1:0] meff, one, mm_r;
   logic [VW:0]   sum, dif;
   logic [EW-1:0] kinv;
   logic          mm_done;

   mau_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .go    (go_ff),
      .x     (mx_ff),
      .y     (my_ff),
      .m     (meff),
      .done  (mm_done),
      .r     (mm_r)
   );

   always_comb begin
      meff = (mod_ff < VW'(2)) ? VW'(1) : mod_ff;
      one  = (meff == VW'(1)) ? '0 : VW'(1);
      kinv = EW'(meff - VW'(1)) - EW'(1);
      if (meff == VW'(1)) begin
         kinv = '0;
      end
      sum = {1'b0, a_ff} + {1'b0, b_ff};
      if (sum >= {1'b0, meff}) begin
         sum = sum - {1'b0, meff};
      end
      if (a_ff >= b_ff) begin
         dif = {1'b0, a_ff} - {1'b0, b_ff};
      end else begin
         dif = {1'b0, a_ff} + {1'b0, meff} - {1'b0, b_ff};
      end
   end

   always_comb begin
      state_in = state_ff;
      mod_in   = mod_ff;
      kind_in  = kind_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      k_in     = k_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      go_in    = 1'b0;
      vld_in   = 1'b0;
      rsp_in   = rsp_ff;
      if (csr_we) begin
         mod_in = csr_wdata;
      end
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in  = req_data.kind;
               b_in     = req_data.operand_b;
               k_in     = req_data.exponent;
               mx_in    = req_data.operand_a;
               my_in    = VW'(1);
               go_in    = 1'b1;
               state_in = S_RA;
            end
         end
         S_RA: begin
            if (mm_done) begin
               a_in     = mm_r;
               mx_in    = b_ff;
               my_in    = VW'(1);
               go_in    = 1'b1;
               state_in = S_RB;
            end
         end
         S_RB: begin
            if (mm_done) begin
               b_in     = mm_r;
               state_in = S_OP;
            end
         end
         S_OP: begin
            y_in = one;
            x_in = a_ff;
            rsp_in.equal  = 1'b0;
            rsp_in.result = '0;
            state_in = S_PL;
            case (kind_ff)
               K_ADD: begin
                  rsp_in.result = sum[VW-1:0];
                  vld_in = 1'b1;
                  state_in = S_IDLE;
               end
               K_SUB: begin
                  rsp_in.result = dif[VW-1:0];
                  vld_in = 1'b1;
                  state_in = S_IDLE;
               end
               K_NEG: begin
                  rsp_in.result = (a_ff != '0) ? (meff - a_ff) : '0;
                  vld_in = 1'b1;
                  state_in = S_IDLE;
               end
               K_EQ: begin
                  rsp_in.equal = (a_ff == b_ff);
                  vld_in = 1'b1;
                  state_in = S_IDLE;
               end
               K_MUL: begin
                  mx_in = a_ff;
                  my_in = b_ff;
                  go_in = 1'b1;
                  state_in = S_MM;
               end
               K_POW: begin
               end
               K_INV: begin
                  k_in = kinv;
               end
               K_DIV: begin
                  k_in = kinv;
                  x_in = b_ff;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_PL: begin
            if (k_ff == '0) begin
               if (kind_ff == K_DIV) begin
                  mx_in = a_ff;
                  my_in = y_ff;
                  go_in = 1'b1;
                  state_in = S_MM;
               end else begin
                  rsp_in.result = y_ff;
                  vld_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (k_ff[0]) begin
               mx_in = y_ff;
               my_in = x_ff;
               go_in = 1'b1;
               state_in = S_PY;
            end else begin
               mx_in = x_ff;
               my_in = x_ff;
               go_in = 1'b1;
               state_in = S_PX;
            end
         end
         S_PY: begin
            if (mm_done) begin
               y_in  = mm_r;
               mx_in = x_ff;
               my_in = x_ff;
               go_in = 1'b1;
               state_in = S_PX;
            end
         end
         S_PX: begin
            if (mm_done) begin
               x_in = mm_r;
               k_in = k_ff >> 1;
               state_in = S_PL;
            end
         end
         S_MM: begin
            if (mm_done) begin
               rsp_in.result = mm_r;
               vld_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mod_ff   <= MOD_RESET;
         go_ff    <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         mod_ff   <= mod_in;
         go_ff    <= go_in;
         vld_ff   <= vld_in;
      end
      kind_ff <= kind_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      k_ff    <= k_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
